[src/ugbs_pkg.sv]
// ----------------------------------------------------------------------------
// ugbs_pkg
// Shared types, code point constants and class tests for the grapheme
// boundary segmenter.
// ----------------------------------------------------------------------------
package ugbs_pkg;

	localparam int CP_W = 21;

	localparam logic [CP_W-1:0] CP_ZWJ      = 21'h0200D;
	localparam logic [CP_W-1:0] CP_CR       = 21'h0000D;
	localparam logic [CP_W-1:0] CP_LF       = 21'h0000A;
	localparam logic [CP_W-1:0] CP_RI_FIRST = 21'h1F1E6;
	localparam logic [CP_W-1:0] CP_RI_LAST  = 21'h1F1FF;

	localparam logic [7:0] CONT_MASK  = 8'h3F;
	localparam logic [7:0] LEAD3_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_MASK = 8'hC0;

	// decoder -> segmenter / result stage
	typedef struct packed {
		logic            done;   // code point completed by this item
		logic            bad;    // sequence dropped (invalid or truncated)
		logic [CP_W-1:0] cp;
	} dec_t;

	// segmenter -> result stage
	typedef struct packed {
		logic brk;
		logic nl;
	} seg_t;

	function automatic logic is_regional(input logic [CP_W-1:0] c);
		return (c >= CP_RI_FIRST) && (c <= CP_RI_LAST);
	endfunction

	// combining marks, variation selectors, emoji modifiers
	function automatic logic is_extend(input logic [CP_W-1:0] c);
		return c inside {[21'h00300:21'h0036F], [21'h01AB0:21'h01AFF],
			[21'h01DC0:21'h01DFF], [21'h020D0:21'h020FF],
			[21'h0FE20:21'h0FE2F], [21'h0FE00:21'h0FE0F],
			[21'hE0100:21'hE01EF], [21'h1F3FB:21'h1F3FF]};
	endfunction

	function automatic logic boundary(input logic [CP_W-1:0] prev,
		input logic [CP_W-1:0] cur, input logic parity);
		logic r;
		r = 1'b1;
		if ((prev == CP_CR) && (cur == CP_LF))
			r = 1'b0;
		else if (is_extend(cur) || (cur == CP_ZWJ) || (prev == CP_ZWJ))
			r = 1'b0;
		else if (is_regional(prev) && is_regional(cur) && parity)
			r = 1'b0;
		return r;
	endfunction

endpackage

[src/utf8_grapheme_boundary_segmenter_core.sv]
// ----------------------------------------------------------------------------
// utf8_grapheme_boundary_segmenter_core
// UTF-8 decoder with simplified grapheme cluster boundary detection.
// ----------------------------------------------------------------------------
// Takes one byte of UTF-8 text per item and returns one item for every
// completed code point or dropped malformed sequence; continuation bytes that
// complete nothing return no item. The block accepts one byte every cycle
// while the result register is free or being emptied: the byte is held in an
// input register, then one pass of decode and boundary logic updates the
// sequence and segmentation state and loads the result register. That state
// update loop (decoder state plus previous code point, regional parity and
// counters) sets the rate of one byte per cycle. While a result waits on
// m_tready the input register can still take a byte if it is empty.
// s_tuser high restarts all counters at that byte; after a byte with s_tlast
// the state returns to its reset value. Offsets and counts are OFFSET_BITS
// wide and saturate.
module utf8_grapheme_boundary_segmenter_core import ugbs_pkg::*; #(
	parameter int OFFSET_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,

	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] first_of_text
	input  logic       s_tlast,   // last_of_text

	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// code_point, start_offset, cluster_index, code_point_index; zero fill
	output logic [((CP_W + 3 * OFFSET_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	output logic [2:0]                                   m_tuser, // brk, nl, malformed
	output logic                                         m_tlast  // text_end
);

	localparam int PAY_W  = CP_W + 3 * OFFSET_BITS;
	localparam int DATA_W = ((PAY_W + 7) / 8) * 8;

	// input register
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;

	// result register
	logic                   v_s2;
	logic [CP_W-1:0]        cp_s2;
	logic [OFFSET_BITS-1:0] start_s2, clus_s2, pidx_s2;
	logic                   brk_s2, nl_s2, bad_s2, end_s2;

	logic                   adv;
	logic                   has_res;
	dec_t                   dec;
	seg_t                   seg;
	logic [OFFSET_BITS-1:0] point_start, cluster_index, point_index;

	// s1 moves on when the result slot is free or being emptied
	assign adv      = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv;
	assign has_res  = dec.done || dec.bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	ugbs_decode #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.data_byte  (byte_s1),
		.first      (first_s1),
		.last       (last_s1),
		.dec        (dec),
		.point_start(point_start)
	);

	ugbs_segment #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_segment (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.dec          (dec),
		.first        (first_s1),
		.last         (last_s1),
		.seg          (seg),
		.cluster_index(cluster_index),
		.point_index  (point_index)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= has_res;
		end else if (m_tready) begin
			v_s2 <= 1'b0;
		end
	end

	// a dropped sequence reports code point zero and no break
	always_ff @(posedge clk) begin
		if (adv && has_res) begin
			cp_s2    <= dec.done ? dec.cp : '0;
			start_s2 <= point_start;
			clus_s2  <= cluster_index;
			pidx_s2  <= point_index;
			brk_s2   <= seg.brk;
			nl_s2    <= seg.nl;
			bad_s2   <= dec.bad;
			end_s2   <= last_s1;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = DATA_W'({pidx_s2, clus_s2, start_s2, cp_s2});
	assign m_tuser  = {bad_s2, nl_s2, brk_s2};
	assign m_tlast  = end_s2;

`ifndef SYNTHESIS
	a_dec_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !(dec.done && dec.bad))
		else $error("decoder reports completion and error together");

	a_nl_brk: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("newline cluster without a break");

	a_bad_res: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> (m_tuser[1:0] == 2'b00) && (cp_s2 == '0))
		else $error("malformed result carries a code point or break");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !m_tready |=> v_s2)
		else $error("pending result lost while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_s1 && v_s2 && !m_tready)
		else $error("input stalled without a full pipeline");
`endif

endmodule

[src/ugbs_decode.sv]
// ----------------------------------------------------------------------------
// ugbs_decode
// UTF-8 byte decoder: sequence state, byte offset and error detection.
// ----------------------------------------------------------------------------
module ugbs_decode import ugbs_pkg::*; #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic [7:0]             data_byte,
	input  logic                   first,
	input  logic                   last,
	output dec_t                   dec,
	output logic [OFFSET_BITS-1:0] point_start
);

	logic [CP_W-1:0]        pv_q;
	logic [1:0]             rem_q;
	logic [OFFSET_BITS-1:0] bcnt_q;
	logic [OFFSET_BITS-1:0] ps_q;

	logic [CP_W-1:0]        pv, npv;
	logic [1:0]             rem, nrem;
	logic [OFFSET_BITS-1:0] bcnt, bcnt_nx, ps;
	logic                   drop, done, trunc;

	always_comb begin
		pv      = first ? '0 : pv_q;
		rem     = first ? '0 : rem_q;
		bcnt    = first ? '0 : bcnt_q;
		ps      = first ? '0 : ps_q;
		npv     = pv;
		nrem    = rem;
		drop    = 1'b0;
		done    = 1'b0;
		dec.cp  = '0;
		if (rem == 2'd0) begin
			ps = bcnt;
			if (!data_byte[7]) begin
				dec.cp = CP_W'(data_byte);
				done   = 1'b1;
			end else if ((data_byte & LEAD3_MASK) == LEAD2_MASK) begin
				if (data_byte < 8'hC2) begin
					drop = 1'b1;
				end else begin
					npv  = CP_W'(data_byte[4:0]);
					nrem = 2'd1;
				end
			end else if (data_byte[7:4] == 4'hE) begin
				npv  = CP_W'(data_byte[3:0]);
				nrem = 2'd2;
			end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
				npv  = CP_W'(data_byte[2:0]);
				nrem = 2'd3;
			end else begin
				drop = 1'b1;
			end
		end else begin
			if ((data_byte & LEAD2_MASK) != 8'h80)
				drop = 1'b1;
			else if (rem == 2'd2 && pv < 21'h10) begin
				// overlong three-byte form, surrogates
				if ((pv == 21'h0 && data_byte < 8'hA0) ||
					(pv == 21'hD && data_byte > 8'h9F))
					drop = 1'b1;
			end else if (rem == 2'd3) begin
				// overlong four-byte form, above U+10FFFF
				if ((pv == 21'h0 && data_byte < 8'h90) ||
					(pv == 21'h4 && data_byte > 8'h8F))
					drop = 1'b1;
			end
			if (!drop) begin
				npv  = {pv[CP_W-7:0], data_byte[5:0] & CONT_MASK[5:0]};
				nrem = rem - 2'd1;
				if (nrem == 2'd0) begin
					dec.cp = npv;
					done   = 1'b1;
				end
			end
		end
		bcnt_nx  = (bcnt == '1) ? bcnt : bcnt + 1'b1;
		trunc    = !drop && last && (nrem != 2'd0);
		dec.done = done;
		dec.bad  = drop || trunc;
	end

	assign point_start = ps;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= '0;
			rem_q  <= '0;
			bcnt_q <= '0;
			ps_q   <= '0;
		end else if (adv) begin
			if (last) begin
				pv_q   <= '0;
				rem_q  <= '0;
				bcnt_q <= '0;
				ps_q   <= '0;
			end else begin
				if (drop || done) begin
					pv_q  <= '0;
					rem_q <= '0;
				end else begin
					pv_q  <= npv;
					rem_q <= nrem;
				end
				bcnt_q <= bcnt_nx;
				ps_q   <= ps;
			end
		end
	end

endmodule

[src/ugbs_segment.sv]
// ----------------------------------------------------------------------------
// ugbs_segment
// Grapheme boundary rules, regional indicator parity and cluster/point counts.
// ----------------------------------------------------------------------------
module ugbs_segment import ugbs_pkg::*; #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  dec_t                   dec,
	input  logic                   first,
	input  logic                   last,
	output seg_t                   seg,
	output logic [OFFSET_BITS-1:0] cluster_index,
	output logic [OFFSET_BITS-1:0] point_index
);

	logic [CP_W-1:0]        prev_q;
	logic                   par_q;
	logic                   at_start_q;
	logic [OFFSET_BITS-1:0] ccnt_q;
	logic [OFFSET_BITS-1:0] pcnt_q;

	logic [CP_W-1:0]        prev;
	logic                   par, par_nx, at_start, brk;
	logic [OFFSET_BITS-1:0] ccnt, ccnt_nx, pcnt, pcnt_nx;

	always_comb begin
		prev     = first ? '0 : prev_q;
		par      = first ? 1'b0 : par_q;
		at_start = first | at_start_q;
		ccnt     = first ? '0 : ccnt_q;
		pcnt     = first ? '0 : pcnt_q;

		brk     = dec.done && (at_start || boundary(prev, dec.cp, par));
		ccnt_nx = (brk && ccnt != '1) ? ccnt + 1'b1 : ccnt;
		pcnt_nx = (dec.done && pcnt != '1) ? pcnt + 1'b1 : pcnt;

		par_nx = par;
		if (dec.done) begin
			if (is_regional(dec.cp))
				par_nx = (!brk && is_regional(prev)) ? ~par : 1'b1;
			else if (!is_extend(dec.cp) && dec.cp != CP_ZWJ)
				par_nx = 1'b0;
		end

		seg.brk = brk;
		seg.nl  = brk && (dec.cp == CP_CR || dec.cp == CP_LF);
		// latest opened cluster; zero before any
		cluster_index = (ccnt_nx == '0) ? '0 : ccnt_nx - 1'b1;
		point_index   = pcnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			par_q      <= 1'b0;
			at_start_q <= 1'b1;
			ccnt_q     <= '0;
			pcnt_q     <= '0;
		end else if (adv) begin
			if (last) begin
				prev_q     <= '0;
				par_q      <= 1'b0;
				at_start_q <= 1'b1;
				ccnt_q     <= '0;
				pcnt_q     <= '0;
			end else begin
				if (dec.done) begin
					prev_q     <= dec.cp;
					at_start_q <= 1'b0;
				end else begin
					prev_q     <= prev;
					at_start_q <= at_start;
				end
				par_q  <= par_nx;
				ccnt_q <= ccnt_nx;
				pcnt_q <= pcnt_nx;
			end
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 grapheme boundary segmenter core.
// ----------------------------------------------------------------------------
// A directed text walks through CR LF, combining marks, ZWJ, the longest and
// largest code points, bad lead bytes and every class of bad continuation but
// the overlong four-byte form, truncation at end of text and a restart in the
// middle of a sequence. After it come random texts, mostly well-formed code
// points (flags in runs, marks, selectors, skin tones, joiner sequences, range
// edges) with some noise bytes mixed in. A bit-accurate segmenter in the bench
// predicts every result item as each byte is accepted; results are compared in
// order. Three phases vary the idling on both sides; the last one also holds
// m_tready low for a long stretch so the core backs up into its input.
module tb;
	import ugbs_pkg::*;

	localparam int OFF_W       = 24;
	localparam int TD_W        = ((CP_W + 3 * OFF_W + 7) / 8) * 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 120;
	localparam int RANDOM_BYTES = 650;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} text_byte_t;

	typedef struct packed {
		logic [TD_W-CP_W-3*OFF_W-1:0] fill;
		logic [CP_W-1:0]              cp;
		logic [OFF_W-1:0]             start;
		logic [OFF_W-1:0]             cluster;
		logic [OFF_W-1:0]             index;
		logic                         brk;
		logic                         nl;
		logic                         bad;
		logic                         tend;
	} point_item_t;

	typedef enum int {
		PICK_ASCII, PICK_NEWLINE, PICK_TWO, PICK_THREE, PICK_MARK, PICK_SELECTOR,
		PICK_SKIN, PICK_JOINER, PICK_ASTRAL, PICK_EDGE, PICK_FLAG
	} cp_pick_t;

	typedef enum int {
		NOISE_ANY, NOISE_STRAY, NOISE_OVERLONG3, NOISE_SURROGATE, NOISE_OVERLONG4,
		NOISE_TOO_BIG, NOISE_CUT_SHORT, NOISE_BAD_LEAD
	} noise_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [7:0]      s_tdata = '0;
	logic            s_tuser = 1'b0;
	logic            s_tlast = 1'b0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [TD_W-1:0] m_tdata;
	logic [2:0]      m_tuser;
	logic            m_tlast;

	utf8_grapheme_boundary_segmenter_core #(
		.OFFSET_BITS(OFF_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	text_byte_t  text_bytes_q[$];
	point_item_t expected_points_q[$];

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  queued_total = 0;
	bit  next_first = 1'b0;
	bit  hold_armed = 1'b0;
	bit  hold_spent = 1'b0;
	int  hold_left = 0;
	int  quiet_cycles = 0;
	int  fail_cnt = 0;
	int  bytes_sent = 0;
	int  points_seen = 0;
	int  breaks_seen = 0;
	int  bad_seen = 0;
	int  texts_seen = 0;

	// ---- segmenter prediction state ----
	logic [CP_W-1:0]  seq_acc = '0;
	logic [1:0]       seq_left = '0;
	logic [CP_W-1:0]  prev_cp = '0;
	logic             ri_odd = 1'b0;
	logic             text_fresh = 1'b1;
	logic [OFF_W-1:0] byte_pos = '0;
	logic [OFF_W-1:0] lead_pos = '0;
	logic [OFF_W-1:0] cluster_cnt = '0;
	logic [OFF_W-1:0] cp_cnt = '0;

	function automatic logic [OFF_W-1:0] bump(input logic [OFF_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic is_flag(input logic [CP_W-1:0] c);
		return (c >= CP_RI_FIRST) && (c <= CP_RI_LAST);
	endfunction

	// marks, selectors and skin tones attach to the previous point
	function automatic logic attaches(input logic [CP_W-1:0] c);
		return (c >= 21'h00300 && c <= 21'h0036F) || (c >= 21'h01AB0 && c <= 21'h01AFF) ||
			(c >= 21'h01DC0 && c <= 21'h01DFF) || (c >= 21'h020D0 && c <= 21'h020FF) ||
			(c >= 21'h0FE00 && c <= 21'h0FE0F) || (c >= 21'h0FE20 && c <= 21'h0FE2F) ||
			(c >= 21'hE0100 && c <= 21'hE01EF) || (c >= 21'h1F3FB && c <= 21'h1F3FF);
	endfunction

	function automatic logic splits(input logic [CP_W-1:0] a, input logic [CP_W-1:0] b,
		input logic odd);
		if (a == CP_CR && b == CP_LF)
			return 1'b0;
		if (attaches(b) || b == CP_ZWJ || a == CP_ZWJ)
			return 1'b0;
		if (is_flag(a) && is_flag(b) && odd)
			return 1'b0;
		return 1'b1;
	endfunction

	task automatic clear_text();
		seq_acc = '0;
		seq_left = '0;
		prev_cp = '0;
		ri_odd = 1'b0;
		text_fresh = 1'b1;
		byte_pos = '0;
		lead_pos = '0;
		cluster_cnt = '0;
		cp_cnt = '0;
	endtask

	// one accepted byte: update the decode / segment state, queue any result
	task automatic segment_byte(input logic [7:0] b, input logic first, input logic last);
		logic            bad;
		logic            done;
		logic            brk;
		logic [CP_W-1:0] cp;
		point_item_t     r;
		bad = 1'b0;
		done = 1'b0;
		cp = '0;
		r = '0;
		if (first)
			clear_text();
		if (seq_left == 2'd0) begin
			lead_pos = byte_pos;
			if (b < 8'h80) begin
				cp = CP_W'(b);
				done = 1'b1;
			end else if ((b & 8'hE0) == 8'hC0) begin
				if (b < 8'hC2)
					bad = 1'b1;
				else begin
					seq_acc = CP_W'(b[4:0]);
					seq_left = 2'd1;
				end
			end else if ((b & 8'hF0) == 8'hE0) begin
				seq_acc = CP_W'(b[3:0]);
				seq_left = 2'd2;
			end else if (b >= 8'hF0 && b <= 8'hF4) begin
				seq_acc = CP_W'(b[2:0]);
				seq_left = 2'd3;
			end else
				bad = 1'b1;
		end else begin
			if ((b & 8'hC0) != 8'h80)
				bad = 1'b1;
			else if (seq_left == 2'd2 && seq_acc < 21'h10) begin
				// overlong three-byte form or surrogate
				if ((seq_acc == 21'h0 && b < 8'hA0) || (seq_acc == 21'hD && b > 8'h9F))
					bad = 1'b1;
			end else if (seq_left == 2'd3) begin
				// overlong four-byte form or above U+10FFFF
				if ((seq_acc == 21'h0 && b < 8'h90) || (seq_acc == 21'h4 && b > 8'h8F))
					bad = 1'b1;
			end
			if (!bad) begin
				seq_acc = {seq_acc[CP_W-7:0], b[5:0]};
				seq_left = seq_left - 2'd1;
				if (seq_left == 2'd0) begin
					cp = seq_acc;
					done = 1'b1;
				end
			end
		end
		byte_pos = bump(byte_pos);

		if (bad) begin
			seq_acc = '0;
			seq_left = '0;
		end else if (last && seq_left != 2'd0)
			bad = 1'b1;	// truncated at end of text

		if (done) begin
			brk = text_fresh || splits(prev_cp, cp, ri_odd);
			if (brk)
				cluster_cnt = bump(cluster_cnt);
			if (is_flag(cp))
				ri_odd = (!brk && is_flag(prev_cp)) ? ~ri_odd : 1'b1;
			else if (!attaches(cp) && cp != CP_ZWJ)
				ri_odd = 1'b0;
			r.cp = cp;
			r.start = lead_pos;
			r.cluster = cluster_cnt - 1'b1;
			r.index = cp_cnt;
			r.brk = brk;
			r.nl = brk && (cp == CP_CR || cp == CP_LF);
			r.tend = last;
			expected_points_q.push_back(r);
			prev_cp = cp;
			text_fresh = 1'b0;
			cp_cnt = bump(cp_cnt);
			seq_acc = '0;
		end else if (bad) begin
			r.start = lead_pos;
			r.cluster = (cluster_cnt == '0) ? '0 : cluster_cnt - 1'b1;
			r.index = cp_cnt;
			r.bad = 1'b1;
			r.tend = last;
			expected_points_q.push_back(r);
		end
		if (last)
			clear_text();
	endtask

	// ---- stimulus building ----
	task automatic put_byte(input logic [7:0] b, input logic last);
		text_byte_t t;
		t.data = b;
		t.first = next_first;
		t.last = last;
		text_bytes_q.push_back(t);
		next_first = 1'b0;
		queued_total++;
	endtask

	task automatic put_cp(input logic [CP_W-1:0] c, input logic last);
		if (c < 21'h80)
			put_byte(c[7:0], last);
		else if (c < 21'h800) begin
			put_byte({3'b110, c[10:6]}, 1'b0);
			put_byte({2'b10, c[5:0]}, last);
		end else if (c < 21'h10000) begin
			put_byte({4'b1110, c[15:12]}, 1'b0);
			put_byte({2'b10, c[11:6]}, 1'b0);
			put_byte({2'b10, c[5:0]}, last);
		end else begin
			put_byte({5'b11110, c[20:18]}, 1'b0);
			put_byte({2'b10, c[17:12]}, 1'b0);
			put_byte({2'b10, c[11:6]}, 1'b0);
			put_byte({2'b10, c[5:0]}, last);
		end
	endtask

	function automatic logic [CP_W-1:0] pick_cp(input cp_pick_t kind);
		logic [CP_W-1:0] c;
		case (kind)
			PICK_ASCII:    c = CP_W'($urandom_range(0, 127));
			PICK_NEWLINE:  c = $urandom_range(0, 1) ? CP_CR : CP_LF;
			PICK_TWO:      c = CP_W'($urandom_range(21'h80, 21'h7FF));
			PICK_THREE: begin
				c = CP_W'($urandom_range(21'h800, 21'hFFFF));
				if (c >= 21'hD800 && c <= 21'hDFFF)
					c = c ^ 21'h4000;
			end
			PICK_MARK: begin
				case ($urandom_range(0, 4))
					0: c = CP_W'($urandom_range(21'h0300, 21'h036F));
					1: c = CP_W'($urandom_range(21'h1AB0, 21'h1AFF));
					2: c = CP_W'($urandom_range(21'h1DC0, 21'h1DFF));
					3: c = CP_W'($urandom_range(21'h20D0, 21'h20FF));
					default: c = CP_W'($urandom_range(21'hFE20, 21'hFE2F));
				endcase
			end
			PICK_SELECTOR: c = $urandom_range(0, 1) ? CP_W'($urandom_range(21'hFE00, 21'hFE0F))
				: CP_W'($urandom_range(21'hE0100, 21'hE01EF));
			PICK_SKIN:     c = CP_W'($urandom_range(21'h1F3FB, 21'h1F3FF));
			PICK_JOINER:   c = CP_ZWJ;
			PICK_ASTRAL:   c = CP_W'($urandom_range(21'h10000, 21'h10FFFF));
			PICK_FLAG:     c = CP_W'($urandom_range(CP_RI_FIRST, CP_RI_LAST));
			default: begin
				// just outside / just inside the class and length borders
				case ($urandom_range(0, 13))
					0: c = 21'h7F;
					1: c = 21'h80;
					2: c = 21'h7FF;
					3: c = 21'h800;
					4: c = 21'hFFFF;
					5: c = 21'h10000;
					6: c = 21'h10FFFF;
					7: c = CP_RI_FIRST - 1'b1;
					8: c = CP_RI_LAST + 1'b1;
					9: c = 21'h02FF;
					10: c = 21'h0370;
					11: c = 21'h1F3FA;
					12: c = CP_ZWJ + 1'b1;
					default: c = 21'hE01F0;
				endcase
			end
		endcase
		return c;
	endfunction

	task automatic put_random_cp();
		cp_pick_t kind;
		int       r;
		int       k;
		r = $urandom_range(0, 12);
		kind = (r > PICK_FLAG) ? PICK_FLAG : cp_pick_t'(r);
		if (kind == PICK_FLAG) begin
			// runs of flags exercise the pairing parity
			for (k = 0; k < $urandom_range(1, 3); k++)
				put_cp(pick_cp(PICK_FLAG), 1'b0);
		end else if (kind == PICK_JOINER) begin
			put_cp(CP_ZWJ, 1'b0);
			put_cp(pick_cp($urandom_range(0, 1) ? PICK_ASTRAL : PICK_ASCII), 1'b0);
		end else
			put_cp(pick_cp(kind), 1'b0);
	endtask

	task automatic put_noise();
		noise_t kind;
		kind = noise_t'($urandom_range(0, 7));
		case (kind)
			NOISE_ANY:   put_byte(8'($urandom_range(0, 255)), 1'b0);
			NOISE_STRAY: put_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
			NOISE_OVERLONG3: begin
				put_byte(8'hE0, 1'b0);
				put_byte(8'($urandom_range(8'h80, 8'h9F)), 1'b0);
			end
			NOISE_SURROGATE: begin
				put_byte(8'hED, 1'b0);
				put_byte(8'($urandom_range(8'hA0, 8'hBF)), 1'b0);
			end
			NOISE_OVERLONG4: begin
				put_byte(8'hF0, 1'b0);
				put_byte(8'($urandom_range(8'h80, 8'h8F)), 1'b0);
			end
			NOISE_TOO_BIG: begin
				put_byte(8'hF4, 1'b0);
				put_byte(8'($urandom_range(8'h90, 8'hBF)), 1'b0);
			end
			NOISE_CUT_SHORT: begin
				put_byte(8'($urandom_range(8'hC2, 8'hF4)), 1'b0);
				put_byte(8'($urandom_range(0, 8'h7F)), 1'b0);
			end
			default:
				put_byte($urandom_range(0, 1) ? 8'($urandom_range(8'hC0, 8'hC1))
					: 8'($urandom_range(8'hF5, 8'hFF)), 1'b0);
		endcase
	endtask

	task automatic gen_texts(input int target);
		int n_cp;
		int k;
		while (queued_total < target) begin
			next_first = $urandom_range(0, 1);
			n_cp = $urandom_range(1, 14);
			for (k = 0; k < n_cp; k++) begin
				if ($urandom_range(0, 9) == 0)
					put_noise();
				else
					put_random_cp();
			end
			case ($urandom_range(0, 9))
				0: put_byte(8'($urandom_range(8'hC2, 8'hF4)), 1'b1);	// truncated
				1, 2: ;	// text runs on into the next one
				default: put_cp(pick_cp(cp_pick_t'($urandom_range(0, PICK_FLAG))), 1'b1);
			endcase
		end
	endtask

	task automatic put_directed();
		next_first = 1'b1;
		put_byte(8'h00, 1'b0);
		put_cp(CP_CR, 1'b0);
		put_cp(CP_LF, 1'b0);	// no break inside CR LF
		put_cp(21'h0301, 1'b0);	// combining acute
		put_cp(CP_ZWJ, 1'b0);
		put_byte(8'h7F, 1'b0);	// no break after ZWJ
		put_cp(21'h10FFFF, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h80, 1'b0);
		put_byte(8'hC1, 1'b0);
		put_byte(8'hE0, 1'b0);	// overlong three-byte
		put_byte(8'h80, 1'b0);
		put_byte(8'hED, 1'b0);	// surrogate
		put_byte(8'hA0, 1'b0);
		put_byte(8'hF4, 1'b0);	// above U+10FFFF
		put_byte(8'h90, 1'b0);
		put_byte(8'hC3, 1'b0);	// lead then non-continuation
		put_byte(8'h41, 1'b0);
		put_byte(8'hE2, 1'b0);
		put_byte(8'h82, 1'b1);	// cut short by end of text
		put_byte(8'hF0, 1'b0);
		put_byte(8'h9F, 1'b0);
		next_first = 1'b1;	// restart drops the pending sequence
		put_byte(8'h0A, 1'b1);
	endtask

	task automatic settle();
		while (text_bytes_q.size() != 0 || s_tvalid || expected_points_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// ---- driver: one byte item per handshake ----
	text_byte_t next_item;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				segment_byte(s_tdata, s_tuser, s_tlast);
				bytes_sent <= bytes_sent + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (text_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_item = text_bytes_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_item.data;
					s_tuser <= next_item.first;
					s_tlast <= next_item.last;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// ---- long receiver hold-off ----
	always @(posedge clk) begin
		if (hold_armed && !hold_spent) begin
			hold_left <= HOLD_CYCLES;
			hold_spent <= 1'b1;
		end else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// ---- monitor: compare result items in order ----
	point_item_t got;
	point_item_t want;

	function automatic string show(input point_item_t p);
		return $sformatf("cp=%06h off=%0d cl=%0d idx=%0d brk=%b nl=%b bad=%b end=%b fill=%b",
			p.cp, p.start, p.cluster, p.index, p.brk, p.nl, p.bad, p.tend, p.fill);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.cp = m_tdata[CP_W-1:0];
				got.start = m_tdata[CP_W +: OFF_W];
				got.cluster = m_tdata[CP_W+OFF_W +: OFF_W];
				got.index = m_tdata[CP_W+2*OFF_W +: OFF_W];
				got.fill = m_tdata[TD_W-1:CP_W+3*OFF_W];
				got.brk = m_tuser[0];
				got.nl = m_tuser[1];
				got.bad = m_tuser[2];
				got.tend = m_tlast;
				points_seen <= points_seen + 1;
				breaks_seen <= breaks_seen + got.brk;
				bad_seen <= bad_seen + got.bad;
				texts_seen <= texts_seen + got.tend;
				if (expected_points_q.size() == 0) begin
					$display("%0t: unexpected item: expected none, got %s", $time, show(got));
					fail_cnt <= fail_cnt + 1;
				end else begin
					want = expected_points_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch: expected %s, got %s", $time, show(want),
							show(got));
						fail_cnt <= fail_cnt + 1;
					end
				end
			end
			m_tready <= (hold_left == 0) && !(hold_armed && !hold_spent) &&
				($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// ---- watchdog: cycles with no handshake on either side ----
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		clear_text();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// phase 1: sender rarely idles, receiver often
		send_idle_pct = 8;
		recv_idle_pct = 56;
		put_directed();
		gen_texts(queued_total + RANDOM_BYTES / 3);
		settle();

		// phase 2: the other way round
		send_idle_pct = 56;
		recv_idle_pct = 8;
		gen_texts(queued_total + RANDOM_BYTES / 3);
		settle();

		// phase 3: no idling, but one long output stall up front
		send_idle_pct = 0;
		recv_idle_pct = 0;
		gen_texts(queued_total + RANDOM_BYTES / 3);
		hold_armed = 1'b1;
		settle();
		repeat (12) @(posedge clk);

		$display("covered %0d bytes in %0d result items: %0d breaks, %0d malformed, %0d texts",
			bytes_sent, points_seen, breaks_seen, bad_seen, texts_seen);
		$display("idling swept over both sides plus a %0d-cycle output stall", HOLD_CYCLES);
		if (fail_cnt == 0 && expected_points_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[utf8_grapheme_boundary_segmenter_core.f]
src/ugbs_pkg.sv
src/ugbs_decode.sv
src/ugbs_segment.sv
src/utf8_grapheme_boundary_segmenter_core.sv
tb/tb.sv
